@@ hw/rtl/rmrs_pkg.sv @@
// Shared types and codes for the reversing motor relay sequencer.
`default_nettype none
package rmrs_pkg;

  localparam int unsigned CntW   = 16;
  localparam int unsigned StateW = 4;
  localparam int unsigned FuncW  = 2;
  localparam int unsigned AddrW  = 5;

  // State codes
  localparam logic [StateW-1:0] ST_IDLE   = 4'd0;
  localparam logic [StateW-1:0] ST_STOP   = 4'd1;
  localparam logic [StateW-1:0] ST_FSTART = 4'd2;
  localparam logic [StateW-1:0] ST_FMOVE  = 4'd3;
  localparam logic [StateW-1:0] ST_FEND   = 4'd4;
  localparam logic [StateW-1:0] ST_FFAULT = 4'd5;
  localparam logic [StateW-1:0] ST_FBLOCK = 4'd6;
  localparam logic [StateW-1:0] ST_BSTART = 4'd7;
  localparam logic [StateW-1:0] ST_BMOVE  = 4'd8;
  localparam logic [StateW-1:0] ST_BEND   = 4'd9;
  localparam logic [StateW-1:0] ST_BFAULT = 4'd10;
  localparam logic [StateW-1:0] ST_BBLOCK = 4'd11;

  // Beat kinds
  localparam logic [FuncW-1:0] FN_TICK = 2'd0;
  localparam logic [FuncW-1:0] FN_REQ  = 2'd1;
  localparam logic [FuncW-1:0] FN_OVC  = 2'd2;

  // Register indexes
  localparam logic [2:0] REG_START_TO_MOVE = 3'd0;
  localparam logic [2:0] REG_MOVE          = 3'd1;
  localparam logic [2:0] REG_MOVE_TO_END   = 3'd2;
  localparam logic [2:0] REG_BLOCK         = 3'd3;
  localparam logic [2:0] REG_IDLE_POLL     = 3'd4;

  // Relay codes: bit 0 relay one, bit 1 relay two
  localparam logic [1:0] RELAY_OFF = 2'b00;
  localparam logic [1:0] RELAY_ONE = 2'b01;
  localparam logic [1:0] RELAY_TWO = 2'b10;

  typedef struct packed {
    logic [CntW-1:0] start_to_move_ticks;
    logic [CntW-1:0] move_ticks;
    logic [CntW-1:0] move_to_end_ticks;
    logic [CntW-1:0] block_ticks;
    logic [CntW-1:0] idle_poll_ticks;
  } rmrs_cfg_t;

  typedef struct packed {
    logic              refused;
    logic [StateW-1:0] state_now;
    logic              adc_start;
    logic              power_switch;
    logic              relay_two;
    logic              relay_one;
  } rmrs_res_t;

endpackage
`default_nettype wire

@@ hw/rtl/reversing_motor_relay_sequencer_top.sv @@
// Top level: stream ports, register file and result register.
`default_nettype none
// Each input beat (tick, state request or overcurrent event) is handled as it
// is accepted and its result beat appears on the master side the cycle after
// that, so one beat per cycle is sustained unless the output stalls. The only
// stall comes from the output register: a new beat is taken whenever that
// register is empty or is being drained in the same cycle. Registers are at
// byte addresses 0x00 start_to_move, 0x04 move, 0x08 move_to_end, 0x0C block,
// 0x10 idle_poll, 16 bits each; write them only while no beat is in flight.
module reversing_motor_relay_sequencer_top (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       s_tvalid,
  output logic                            s_tready,
  input  wire logic [7:0]                 s_tdata,  // func[1:0], requested_state[5:2]
  output logic                            m_tvalid,
  input  wire logic                       m_tready,
  // relay_one[0], relay_two[1], power_switch[2], adc_start[3], state_now[7:4], refused[8]
  output logic [15:0]                     m_tdata,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [rmrs_pkg::AddrW-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import rmrs_pkg::*;

  rmrs_cfg_t  cfg_q;
  rmrs_res_t  res, res_q;
  logic       m_valid_q, m_valid_d;
  logic       accept, cfg_wr;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign reg_idx = paddr[AddrW-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_to_move_ticks <= CntW'(100);
      cfg_q.move_ticks          <= CntW'(5000);
      cfg_q.move_to_end_ticks   <= CntW'(100);
      cfg_q.block_ticks         <= CntW'(1000);
      cfg_q.idle_poll_ticks     <= CntW'(10);
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_START_TO_MOVE: cfg_q.start_to_move_ticks <= pwdata[CntW-1:0];
        REG_MOVE:          cfg_q.move_ticks          <= pwdata[CntW-1:0];
        REG_MOVE_TO_END:   cfg_q.move_to_end_ticks   <= pwdata[CntW-1:0];
        REG_BLOCK:         cfg_q.block_ticks         <= pwdata[CntW-1:0];
        REG_IDLE_POLL:     cfg_q.idle_poll_ticks     <= pwdata[CntW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_START_TO_MOVE: prdata = {16'h0, cfg_q.start_to_move_ticks};
      REG_MOVE:          prdata = {16'h0, cfg_q.move_ticks};
      REG_MOVE_TO_END:   prdata = {16'h0, cfg_q.move_to_end_ticks};
      REG_BLOCK:         prdata = {16'h0, cfg_q.block_ticks};
      REG_IDLE_POLL:     prdata = {16'h0, cfg_q.idle_poll_ticks};
      default:           prdata = '0;
    endcase
  end

  assign s_tready = ~m_valid_q | m_tready;
  assign accept   = s_tvalid & s_tready;

  rmrs_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (accept),
    .func_i (s_tdata[1:0]),
    .req_i  (s_tdata[5:2]),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  always_comb begin
    m_valid_d = m_valid_q;
    if (accept) m_valid_d = 1'b1;
    else if (m_tready) m_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res;
    end
  end

  assign m_tvalid = m_valid_q;
  assign m_tdata  = {7'h0, res_q};

endmodule
`default_nettype wire

@@ hw/rtl/rmrs_core.sv @@
// Sequencer state, request guards and manager step; one beat per cycle while step_i is high.
`default_nettype none
module rmrs_core (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     step_i,
  input  wire logic [rmrs_pkg::FuncW-1:0]  func_i,
  input  wire logic [rmrs_pkg::StateW-1:0] req_i,
  input  wire rmrs_pkg::rmrs_cfg_t      cfg_i,
  output rmrs_pkg::rmrs_res_t           res_o
);
  import rmrs_pkg::*;

  typedef struct packed {
    logic              ok;
    logic              clr_wait;
    logic [StateW-1:0] next;
  } guard_t;

  logic [StateW-1:0] cur_q, cur_d, pend_q, pend_d, hand_q, hand_d;
  logic [CntW-1:0]   wait_q, wait_d, wait_dec;
  logic [1:0]        relay_q, relay_d;
  logic              sw_q, sw_d;
  logic [StateW-1:0] mgr_cur;
  logic              adc, refused;
  guard_t            g;

  function automatic guard_t guard(input logic [StateW-1:0] req, input logic [StateW-1:0] c);
    guard_t r;
    r = '{ok: 1'b1, clr_wait: 1'b0, next: c};
    unique case (req)
      ST_IDLE:   r.next = ST_IDLE;
      ST_FBLOCK: if (c == ST_FSTART || c == ST_FMOVE || c == ST_FEND) r.next = ST_FBLOCK;
                 else r.ok = 1'b0;
      ST_BBLOCK: if (c == ST_BSTART || c == ST_BMOVE || c == ST_BEND) r.next = ST_BBLOCK;
                 else r.ok = 1'b0;
      ST_FSTART: if (c == ST_STOP || c == ST_BBLOCK) begin
                   r.next = ST_FSTART; r.clr_wait = 1'b1;
                 end else r.ok = 1'b0;
      ST_BSTART: if (c == ST_STOP || c == ST_FBLOCK) begin
                   r.next = ST_BSTART; r.clr_wait = 1'b1;
                 end else r.ok = 1'b0;
      ST_FEND:   if (c == ST_FMOVE || c == ST_FSTART || c == ST_FEND) begin
                   r.next = ST_FEND; r.clr_wait = 1'b1;
                 end else r.ok = 1'b0;
      ST_BEND:   if (c == ST_BMOVE || c == ST_BSTART || c == ST_BEND) begin
                   r.next = ST_BEND; r.clr_wait = 1'b1;
                 end else r.ok = 1'b0;
      ST_FFAULT: if (c == ST_FMOVE || c == ST_FSTART || c == ST_FEND || c == ST_FFAULT) begin
                   r.next = ST_FEND; r.clr_wait = 1'b1;
                 end else r.ok = 1'b0;
      ST_BFAULT: if (c == ST_BMOVE || c == ST_BSTART || c == ST_BEND || c == ST_BFAULT) begin
                   r.next = ST_BEND; r.clr_wait = 1'b1;
                 end else r.ok = 1'b0;
      ST_BMOVE:  if (c == ST_BSTART) r.next = ST_BMOVE;
                 else r.ok = 1'b0;
      ST_FMOVE:  if (c == ST_FSTART) r.next = ST_FMOVE;
                 else r.ok = 1'b0;
      ST_STOP:   if (c == ST_BEND || c == ST_FEND || c == ST_FBLOCK || c == ST_BBLOCK)
                   r.next = ST_STOP;
                 else r.ok = 1'b0;
      default:   r.next = c;
    endcase
    return r;
  endfunction

  assign wait_dec = (wait_q != '0) ? wait_q - CntW'(1) : wait_q;
  assign mgr_cur  = (pend_q != ST_IDLE) ? pend_q : cur_q;
  assign g        = guard(req_i, cur_q);

  always_comb begin
    cur_d   = cur_q;
    pend_d  = pend_q;
    hand_d  = hand_q;
    wait_d  = wait_q;
    relay_d = relay_q;
    sw_d    = sw_q;
    adc     = 1'b0;
    refused = 1'b0;
    unique case (func_i)
      FN_TICK: begin
        wait_d = wait_dec;
        if (wait_dec == '0) begin
          cur_d  = mgr_cur;
          pend_d = ST_IDLE;
          if (mgr_cur == hand_q) begin
            wait_d = cfg_i.idle_poll_ticks;
          end else begin
            unique case (mgr_cur)
              ST_BSTART: begin
                relay_d = RELAY_ONE;
                hand_d  = mgr_cur;
                cur_d   = ST_BMOVE;
                wait_d  = cfg_i.start_to_move_ticks;
              end
              ST_FSTART: begin
                relay_d = RELAY_TWO;
                hand_d  = mgr_cur;
                cur_d   = ST_FMOVE;
                wait_d  = cfg_i.start_to_move_ticks;
              end
              ST_FMOVE, ST_BMOVE: begin
                sw_d   = 1'b1;
                adc    = 1'b1;
                hand_d = mgr_cur;
                cur_d  = (mgr_cur == ST_FMOVE) ? ST_FEND : ST_BEND;
                wait_d = cfg_i.move_ticks;
              end
              ST_FEND, ST_BEND: begin
                sw_d   = 1'b0;
                hand_d = mgr_cur;
                cur_d  = ST_STOP;
                wait_d = cfg_i.move_to_end_ticks;
              end
              ST_FBLOCK, ST_BBLOCK: begin
                relay_d = RELAY_OFF;
                hand_d  = mgr_cur;
                wait_d  = cfg_i.block_ticks;
                pend_d  = ST_STOP;
              end
              ST_STOP: begin
                relay_d = RELAY_OFF;
                hand_d  = ST_STOP;
                wait_d  = cfg_i.idle_poll_ticks;
              end
              default: ;
            endcase
          end
        end
      end
      FN_REQ: begin
        refused = ~g.ok;
        if (g.ok) begin
          cur_d  = g.next;
          pend_d = ST_IDLE;
          if (g.clr_wait) wait_d = '0;
        end
      end
      FN_OVC: begin
        if (cur_q == ST_BMOVE) cur_d = ST_BBLOCK;
        else if (cur_q == ST_FMOVE) cur_d = ST_FBLOCK;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q   <= ST_STOP;
      pend_q  <= ST_IDLE;
      hand_q  <= ST_STOP;
      wait_q  <= '0;
      relay_q <= RELAY_OFF;
      sw_q    <= 1'b0;
    end else if (step_i) begin
      cur_q   <= cur_d;
      pend_q  <= pend_d;
      hand_q  <= hand_d;
      wait_q  <= wait_d;
      relay_q <= relay_d;
      sw_q    <= sw_d;
    end
  end

  assign res_o = '{refused: refused, state_now: cur_d, adc_start: adc,
                   power_switch: sw_d, relay_two: relay_d[1], relay_one: relay_d[0]};

`ifndef ASSERT_OFF
  a_relay_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    relay_q != 2'b11) else $error("both direction relays on");

  a_pend_codes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q == ST_IDLE || pend_q == ST_STOP) else $error("bad pending code");

  a_adc_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && adc |=> sw_q && (cur_q == ST_FEND || cur_q == ST_BEND))
    else $error("converter start without switch on");

  a_refused_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && refused |=> cur_q == $past(cur_q) && wait_q == $past(wait_q))
    else $error("refused request changed state");
`endif

endmodule
`default_nettype wire

@@ test/rmrs_checker.sv @@
// Checker for the motor relay sequencer: tracks config writes, predicts and compares result beats.
`timescale 1ns / 1ps
module rmrs_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_tvalid,
  input  logic                        s_tready,
  input  logic [7:0]                  s_tdata,
  input  logic                        m_tvalid,
  input  logic                        m_tready,
  input  logic [15:0]                 m_tdata,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [rmrs_pkg::AddrW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output int unsigned                 fail_count,
  output int unsigned                 outstanding,
  output int unsigned                 n_results,
  output int unsigned                 n_moves,
  output int unsigned                 n_refused,
  output int unsigned                 n_blocks
);
  import rmrs_pkg::*;

  rmrs_cfg_t         timing;
  logic [StateW-1:0] cur_st;
  logic [StateW-1:0] pend_st;
  logic [StateW-1:0] done_st;
  logic [CntW-1:0]   wait_cnt;
  logic [1:0]        relays;
  logic              pwr;
  rmrs_res_t         motor_q[$];
  rmrs_res_t         want;
  rmrs_res_t         got;

  // Guarded state change; returns 1 when the request is refused.
  function automatic bit guard_request(input logic [StateW-1:0] req);
    logic [StateW-1:0] c;
    logic [StateW-1:0] nxt;
    bit                ok;
    bit                clr;
    c   = cur_st;
    nxt = c;
    ok  = 1'b1;
    clr = 1'b0;
    case (req)
      ST_IDLE:   nxt = ST_IDLE;
      ST_FBLOCK: begin
        ok  = c inside {ST_FSTART, ST_FMOVE, ST_FEND};
        nxt = ST_FBLOCK;
      end
      ST_BBLOCK: begin
        ok  = c inside {ST_BSTART, ST_BMOVE, ST_BEND};
        nxt = ST_BBLOCK;
      end
      ST_FSTART: begin
        ok  = c inside {ST_STOP, ST_BBLOCK};
        nxt = ST_FSTART;
        clr = 1'b1;
      end
      ST_BSTART: begin
        ok  = c inside {ST_STOP, ST_FBLOCK};
        nxt = ST_BSTART;
        clr = 1'b1;
      end
      ST_FEND: begin
        ok  = c inside {ST_FMOVE, ST_FSTART, ST_FEND};
        nxt = ST_FEND;
        clr = 1'b1;
      end
      ST_BEND: begin
        ok  = c inside {ST_BMOVE, ST_BSTART, ST_BEND};
        nxt = ST_BEND;
        clr = 1'b1;
      end
      ST_FFAULT: begin
        ok  = c inside {ST_FMOVE, ST_FSTART, ST_FEND, ST_FFAULT};
        nxt = ST_FEND;
        clr = 1'b1;
      end
      ST_BFAULT: begin
        ok  = c inside {ST_BMOVE, ST_BSTART, ST_BEND, ST_BFAULT};
        nxt = ST_BEND;
        clr = 1'b1;
      end
      ST_FMOVE: begin
        ok  = (c == ST_FSTART);
        nxt = ST_FMOVE;
      end
      ST_BMOVE: begin
        ok  = (c == ST_BSTART);
        nxt = ST_BMOVE;
      end
      ST_STOP: begin
        ok  = c inside {ST_BEND, ST_FEND, ST_FBLOCK, ST_BBLOCK};
        nxt = ST_STOP;
      end
      default: ;
    endcase
    if (!ok) return 1'b1;
    cur_st = nxt;
    if (clr) wait_cnt = '0;
    pend_st = ST_IDLE;
    return 1'b0;
  endfunction

  // Stage handler run when the wait expires; returns 1 on move entry.
  function automatic bit run_stage();
    bit adc;
    adc = 1'b0;
    if (pend_st != ST_IDLE) begin
      cur_st  = pend_st;
      pend_st = ST_IDLE;
    end
    if (cur_st == done_st) begin
      wait_cnt = timing.idle_poll_ticks;
      return 1'b0;
    end
    case (cur_st)
      ST_BSTART: begin
        relays  = RELAY_ONE;
        done_st = cur_st;
        void'(guard_request(ST_BMOVE));
        wait_cnt = timing.start_to_move_ticks;
      end
      ST_FSTART: begin
        relays  = RELAY_TWO;
        done_st = cur_st;
        void'(guard_request(ST_FMOVE));
        wait_cnt = timing.start_to_move_ticks;
      end
      ST_FMOVE, ST_BMOVE: begin
        pwr     = 1'b1;
        adc     = 1'b1;
        done_st = cur_st;
        void'(guard_request(cur_st == ST_FMOVE ? ST_FFAULT : ST_BFAULT));
        wait_cnt = timing.move_ticks;
      end
      ST_FEND, ST_BEND: begin
        pwr     = 1'b0;
        done_st = cur_st;
        void'(guard_request(ST_STOP));
        wait_cnt = timing.move_to_end_ticks;
      end
      ST_FBLOCK, ST_BBLOCK: begin
        relays   = RELAY_OFF;
        done_st  = cur_st;
        wait_cnt = timing.block_ticks;
        pend_st  = ST_STOP;
      end
      ST_STOP: begin
        relays   = RELAY_OFF;
        cur_st   = ST_STOP;
        pend_st  = ST_IDLE;
        done_st  = ST_STOP;
        wait_cnt = timing.idle_poll_ticks;
      end
      default: ;
    endcase
    return adc;
  endfunction

  function automatic rmrs_res_t predict_motor(input logic [FuncW-1:0] fn,
                                              input logic [StateW-1:0] req);
    rmrs_res_t r;
    r = '0;
    case (fn)
      FN_TICK: begin
        if (wait_cnt != '0) wait_cnt = wait_cnt - 1'b1;
        if (wait_cnt == '0) r.adc_start = run_stage();
      end
      FN_REQ: r.refused = guard_request(req);
      FN_OVC: begin
        if (cur_st == ST_BMOVE) cur_st = ST_BBLOCK;
        else if (cur_st == ST_FMOVE) cur_st = ST_FBLOCK;
      end
      default: ;
    endcase
    r.relay_one    = relays[0];
    r.relay_two    = relays[1];
    r.power_switch = pwr;
    r.state_now    = cur_st;
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timing      <= '{16'd100, 16'd5000, 16'd100, 16'd1000, 16'd10};
      cur_st      = ST_STOP;
      pend_st     = ST_IDLE;
      done_st     = ST_STOP;
      wait_cnt    = '0;
      relays      = RELAY_OFF;
      pwr         = 1'b0;
      motor_q.delete();
      fail_count  = 0;
      n_results   = 0;
      n_moves     = 0;
      n_refused   = 0;
      n_blocks    = 0;
      outstanding <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = rmrs_res_t'(m_tdata[8:0]);
        if (motor_q.size() == 0) begin
          $error("unexpected result beat: tdata %h", m_tdata);
          fail_count++;
        end else begin
          want = motor_q.pop_front();
          check_field("relay_one", want.relay_one, got.relay_one);
          check_field("relay_two", want.relay_two, got.relay_two);
          check_field("power_switch", want.power_switch, got.power_switch);
          check_field("adc_start", want.adc_start, got.adc_start);
          check_field("state_now", want.state_now, got.state_now);
          check_field("refused", want.refused, got.refused);
          n_results++;
          if (want.adc_start) n_moves++;
          if (want.refused) n_refused++;
          if (want.state_now inside {ST_FBLOCK, ST_BBLOCK}) n_blocks++;
        end
      end
      if (s_tvalid && s_tready) motor_q.push_back(predict_motor(s_tdata[1:0], s_tdata[5:2]));
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_START_TO_MOVE: timing.start_to_move_ticks <= pwdata[CntW-1:0];
          REG_MOVE:          timing.move_ticks          <= pwdata[CntW-1:0];
          REG_MOVE_TO_END:   timing.move_to_end_ticks   <= pwdata[CntW-1:0];
          REG_BLOCK:         timing.block_ticks         <= pwdata[CntW-1:0];
          REG_IDLE_POLL:     timing.idle_poll_ticks     <= pwdata[CntW-1:0];
          default: ;
        endcase
      end
      outstanding <= motor_q.size();
    end
  end

endmodule

@@ test/tb.sv @@
// Testbench top for the motor relay sequencer: clock, reset, stimulus, handshake idling, verdict.
`timescale 1ns / 1ps
module tb;
  import rmrs_pkg::*;

  localparam logic [FuncW-1:0] FN_UNUSED = 2'd3;
  localparam int unsigned QUIET_LIMIT = 5000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned PHASE_BEATS = 190;

  logic              clk;
  logic              rst_n;
  logic              s_tvalid;
  logic              s_tready;
  logic [7:0]        s_tdata;   // func[1:0], requested_state[5:2]
  logic              m_tvalid;
  logic              m_tready;
  // relay_one[0], relay_two[1], power_switch[2], adc_start[3], state_now[7:4], refused[8]
  logic [15:0]       m_tdata;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [AddrW-1:0]  paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  int unsigned fail_count;
  int unsigned outstanding;
  int unsigned n_results;
  int unsigned n_moves;
  int unsigned n_refused;
  int unsigned n_blocks;

  int unsigned send_idle;
  int unsigned recv_stall;
  int unsigned beats_sent;
  bit          hold_req;

  reversing_motor_relay_sequencer_top uut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  rmrs_checker chk (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .fail_count  (fail_count),
    .outstanding (outstanding),
    .n_results   (n_results),
    .n_moves     (n_moves),
    .n_refused   (n_refused),
    .n_blocks    (n_blocks)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin : receiver
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_stall);
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("FAIL reversing_motor_relay_sequencer_top");
    $finish;
  end

  task automatic send_beat(input logic [FuncW-1:0] fn, input logic [StateW-1:0] req);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, req, fn};
    do @(posedge clk); while (!s_tready);
    if (fn != FN_UNUSED) beats_sent++;
  endtask

  task automatic tick();
    send_beat(FN_TICK, StateW'($urandom_range(15)));
  endtask

  task automatic apb_write(input logic [2:0] idx, input logic [CntW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'({idx, 2'b00});
    pwdata  <= 32'(val);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_timing(input logic [CntW-1:0] t_start, input logic [CntW-1:0] t_move,
                             input logic [CntW-1:0] t_end, input logic [CntW-1:0] t_block,
                             input logic [CntW-1:0] t_poll);
    drain();
    apb_write(REG_START_TO_MOVE, t_start);
    apb_write(REG_MOVE, t_move);
    apb_write(REG_MOVE_TO_END, t_end);
    apb_write(REG_BLOCK, t_block);
    apb_write(REG_IDLE_POLL, t_poll);
  endtask

  // One start-to-stop run in a random direction with random disturbances.
  task automatic motor_run();
    bit                back;
    logic [FuncW-1:0]  fn;
    back = 1'($urandom_range(1));
    send_beat(FN_REQ, back ? ST_BSTART : ST_FSTART);
    repeat ($urandom_range(6)) tick();
    case ($urandom_range(6))
      0, 1: send_beat(FN_OVC, StateW'($urandom_range(15)));
      2: send_beat(FN_REQ, back ? ST_BEND : ST_FEND);
      3: send_beat(FN_REQ, back ? ST_BFAULT : ST_FFAULT);
      4: send_beat(FN_REQ, back ? ST_BMOVE : ST_FMOVE);
      5: send_beat(FN_REQ, back ? ST_BBLOCK : ST_FBLOCK);
      default: ;
    endcase
    repeat ($urandom_range(12)) tick();
    if ($urandom_range(3) == 0) send_beat(FN_REQ, ST_STOP);
    if ($urandom_range(3) == 0) begin
      fn = FuncW'($urandom_range(3));
      send_beat(fn, StateW'($urandom_range(15, 1)));
    end
  endtask

  task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct);
    int unsigned stop_at;
    send_idle  = idle_pct;
    recv_stall = stall_pct;
    stop_at    = beats_sent + PHASE_BEATS;
    while (beats_sent < stop_at) motor_run();
  endtask

  function automatic logic [CntW-1:0] short_wait();
    return CntW'($urandom_range(4));
  endfunction

  function automatic logic [CntW-1:0] mixed_wait();
    return $urandom_range(1) ? CntW'($urandom_range(6)) : 16'hFFFF;
  endfunction

  initial begin
    rst_n      <= 1'b0;
    s_tvalid   <= 1'b0;
    s_tdata    <= '0;
    m_tready   <= 1'b0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    send_idle  = 0;
    recv_stall = 0;
    beats_sent = 0;
    hold_req   = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset timing: guards, overcurrent, ignored beats
    tick();
    send_beat(FN_REQ, ST_FMOVE);
    send_beat(FN_REQ, ST_FSTART);
    tick();
    send_beat(FN_OVC, 4'd0);
    send_beat(FN_REQ, ST_BSTART);
    tick();
    send_beat(FN_REQ, ST_BFAULT);
    tick();
    send_beat(FN_OVC, 4'd15);
    send_beat(FN_UNUSED, 4'd15);
    send_beat(FN_REQ, 4'd13);
    send_beat(FN_REQ, 4'd12);

    // zero waits: every tick runs a stage
    load_timing('0, '0, '0, '0, '0);
    send_beat(FN_REQ, ST_BSTART);
    send_beat(FN_REQ, ST_BMOVE);
    tick();
    tick();
    tick();
    send_beat(FN_REQ, ST_FSTART);
    tick();
    tick();
    send_beat(FN_REQ, ST_FBLOCK);
    tick();
    tick();

    load_timing(short_wait(), short_wait(), short_wait(), short_wait(), short_wait());
    run_phase(0, 0);
    load_timing('0, '0, '0, '0, '0);
    run_phase(49, 0);
    load_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_phase(0, 49);
    load_timing(mixed_wait(), mixed_wait(), mixed_wait(), mixed_wait(), mixed_wait());
    run_phase(6, 6);
    load_timing(short_wait(), short_wait(), short_wait(), short_wait(), short_wait());
    hold_req = 1'b1;
    run_phase(0, 0);

    // idle request: no guard lets the state out again
    send_beat(FN_REQ, ST_IDLE);
    tick();
    send_beat(FN_REQ, ST_STOP);
    tick();

    drain();
    $display("Checked %0d result beats across seven timing settings and four idling mixes.",
             n_results);
    $display("Seen: %0d move entries, %0d refused requests, %0d block-stage beats.",
             n_moves, n_refused, n_blocks);
    if (fail_count == 0 && outstanding == 0) begin
      $display("PASS reversing_motor_relay_sequencer_top");
    end else begin
      $display("FAIL reversing_motor_relay_sequencer_top");
    end
    $finish;
  end

endmodule
